>>> design/msort_pkg.sv
// Package for the merge sorter block: stream widths, default sizes and the
// sequencer state encoding. No dependencies; used by the top level and its checker.
package msort_pkg;

    // Width of the value field on both stream channels.
    localparam int DATA_W = 32;

    // Default buffer size and stored value width.
    localparam int DEF_CAPACITY    = 64;
    localparam int DEF_VALUE_WIDTH = 32;

    // Sequencer states, one-hot.
    typedef enum logic [3:0] {
        ST_IDLE  = 4'b0001,
        ST_PRIME = 4'b0010,
        ST_MERGE = 4'b0100,
        ST_EMIT  = 4'b1000
    } state_t;

endpackage

>>> design/merge_sorter_unit.sv
// Stable ascending merge sorter with a streaming input and output.
// Depends on msort_pkg. Uses two ping-pong buffer memories and one shared comparator.
//
//  channel | dir | tdata bits             | tlast              | tuser
//  --------+-----+------------------------+--------------------+--------------
//  s_*     | in  | [31:0] value           | is_last            | -
//  m_*     | out | [31:0] sorted_value    | last_out           | dropped
//
// Loading: the input stays ready in idle, so requests are taken back to back.
// After the last request, a set of n values takes ceil(log2 n) merge passes;
// each primes the read registers and then makes one comparator decision and one
// memory write per cycle. The output phase follows. Reset (rst_n low,
// asynchronous) empties the buffer and the output register. The input is not
// ready from the last request until the final result is loaded into the output
// register; output stalls hold the output phase while they last.
module merge_sorter_unit
    import msort_pkg::*;
#(
    parameter int CAPACITY    = DEF_CAPACITY,
    parameter int VALUE_WIDTH = DEF_VALUE_WIDTH
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              s_tvalid,
    output logic              s_tready,
    input  logic [DATA_W-1:0] s_tdata,   // [31:0] value
    input  logic              s_tlast,   // is_last
    output logic              m_tvalid,
    input  logic              m_tready,
    output logic [DATA_W-1:0] m_tdata,   // [31:0] sorted_value
    output logic              m_tlast,   // last_out
    output logic              m_tuser    // [0] dropped
);

    localparam int AW   = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int PW   = $clog2(CAPACITY) + 1;
    localparam int SW   = PW + 1;
    localparam int WIDE = (VALUE_WIDTH > DATA_W) ? VALUE_WIDTH : DATA_W;
    localparam int DEPTH = CAPACITY;

    // Ping-pong buffers; the source of the current pass is selected by src_reg.
    logic signed [VALUE_WIDTH-1:0] mem0 [DEPTH];
    logic signed [VALUE_WIDTH-1:0] mem1 [DEPTH];

    state_t                        state_reg, state_next;
    logic [PW-1:0]                 fill_reg, fill_next;
    logic                          ovf_reg, ovf_next;
    logic                          src_reg, src_next;
    logic [PW-1:0]                 run_reg, run_next;
    logic [PW-1:0]                 a_reg, a_next;
    logic [PW-1:0]                 b_reg, b_next;
    logic [PW-1:0]                 mid_reg, mid_next;
    logic [PW-1:0]                 hi_reg, hi_next;
    logic [PW-1:0]                 k_reg, k_next;
    logic signed [VALUE_WIDTH-1:0] rd_a_reg, rd_b_reg;
    logic                          m_valid_reg, m_valid_next;
    logic [DATA_W-1:0]             m_data_reg, m_data_next;
    logic                          m_last_reg, m_last_next;
    logic                          m_user_reg, m_user_next;

    logic                          we0, we1;
    logic [AW-1:0]                 waddr;
    logic signed [VALUE_WIDTH-1:0] wdata;
    logic [WIDE-1:0]               in_ext;
    logic signed [WIDE-1:0]        out_ext;
    logic                          take_a;
    logic [PW-1:0]                 n_load;
    logic [PW-1:0]                 run2;
    logic [SW-1:0]                 sum_mid, sum_hi, sum_mid2, sum_hi2;

    // Input value trimmed to the stored width; output sign-extended back.
    assign in_ext  = WIDE'(s_tdata);
    assign out_ext = WIDE'(rd_a_reg);

    // Shared comparator: the earlier run wins on equal keys.
    assign take_a = (a_reg < mid_reg) && ((b_reg >= hi_reg) || (rd_a_reg <= rd_b_reg));

    // Bounds of the next group in this pass and of the first group of the next pass.
    assign run2     = PW'({run_reg, 1'b0});
    assign sum_mid  = SW'(hi_reg) + SW'(run_reg);
    assign sum_hi   = SW'(hi_reg) + SW'({run_reg, 1'b0});
    assign sum_mid2 = SW'(run2);
    assign sum_hi2  = SW'({run2, 1'b0});
    assign n_load   = (fill_reg < PW'(CAPACITY)) ? fill_reg + PW'(1) : fill_reg;

    // Sequencer.
    always_comb
    begin
        state_next   = state_reg;
        fill_next    = fill_reg;
        ovf_next     = ovf_reg;
        src_next     = src_reg;
        run_next     = run_reg;
        a_next       = a_reg;
        b_next       = b_reg;
        mid_next     = mid_reg;
        hi_next      = hi_reg;
        k_next       = k_reg;
        we0          = 1'b0;
        we1          = 1'b0;
        waddr        = fill_reg[AW-1:0];
        wdata        = $signed(in_ext[VALUE_WIDTH-1:0]);
        m_valid_next = m_valid_reg & ~m_tready;
        m_data_next  = m_data_reg;
        m_last_next  = m_last_reg;
        m_user_next  = m_user_reg;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    if (fill_reg < PW'(CAPACITY))
                    begin
                        we0       = 1'b1;
                        fill_next = fill_reg + PW'(1);
                    end
                    else
                    begin
                        ovf_next = 1'b1;
                    end
                    if (s_tlast)
                    begin
                        run_next   = PW'(1);
                        a_next     = '0;
                        b_next     = PW'(1);
                        mid_next   = PW'(1);
                        hi_next    = (n_load >= PW'(2)) ? PW'(2) : n_load;
                        k_next     = '0;
                        state_next = ST_PRIME;
                    end
                end
            end

            ST_PRIME:
            begin
                // Read registers load the heads at a_reg and b_reg here.
                state_next = (run_reg < fill_reg) ? ST_MERGE : ST_EMIT;
            end

            ST_MERGE:
            begin
                we0    = src_reg;
                we1    = ~src_reg;
                waddr  = k_reg[AW-1:0];
                wdata  = take_a ? rd_a_reg : rd_b_reg;
                a_next = a_reg + PW'(take_a);
                b_next = take_a ? b_reg : b_reg + PW'(1);
                k_next = k_reg + PW'(1);
                if (k_reg + PW'(1) == hi_reg)
                begin
                    if (hi_reg == fill_reg)
                    begin
                        // Pass done: swap buffers and start over with doubled runs.
                        run_next   = run2;
                        src_next   = ~src_reg;
                        a_next     = '0;
                        k_next     = '0;
                        mid_next   = (sum_mid2 > SW'(fill_reg)) ? fill_reg : run2;
                        b_next     = (sum_mid2 > SW'(fill_reg)) ? fill_reg : run2;
                        hi_next    = (sum_hi2 > SW'(fill_reg)) ? fill_reg : sum_hi2[PW-1:0];
                        state_next = ST_PRIME;
                    end
                    else
                    begin
                        a_next   = hi_reg;
                        k_next   = hi_reg;
                        mid_next = (sum_mid > SW'(fill_reg)) ? fill_reg : sum_mid[PW-1:0];
                        b_next   = (sum_mid > SW'(fill_reg)) ? fill_reg : sum_mid[PW-1:0];
                        hi_next  = (sum_hi > SW'(fill_reg)) ? fill_reg : sum_hi[PW-1:0];
                    end
                end
            end

            ST_EMIT:
            begin
                if (!m_valid_reg || m_tready)
                begin
                    m_valid_next = 1'b1;
                    m_data_next  = out_ext[DATA_W-1:0];
                    m_last_next  = (a_reg + PW'(1) == fill_reg);
                    m_user_next  = ovf_reg;
                    a_next       = a_reg + PW'(1);
                    if (a_reg + PW'(1) == fill_reg)
                    begin
                        fill_next  = '0;
                        ovf_next   = 1'b0;
                        src_next   = 1'b0;
                        state_next = ST_IDLE;
                    end
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Buffer memories: one write port, two registered read ports on the source.
    always_ff @(posedge clk)
    begin
        if (we0)
        begin
            mem0[waddr] <= wdata;
        end
        if (we1)
        begin
            mem1[waddr] <= wdata;
        end
        rd_a_reg <= src_next ? mem1[a_next[AW-1:0]] : mem0[a_next[AW-1:0]];
        rd_b_reg <= src_next ? mem1[b_next[AW-1:0]] : mem0[b_next[AW-1:0]];
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            fill_reg    <= '0;
            ovf_reg     <= 1'b0;
            src_reg     <= 1'b0;
            m_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            fill_reg    <= fill_next;
            ovf_reg     <= ovf_next;
            src_reg     <= src_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // Datapath registers.
    always_ff @(posedge clk)
    begin
        run_reg    <= run_next;
        a_reg      <= a_next;
        b_reg      <= b_next;
        mid_reg    <= mid_next;
        hi_reg     <= hi_next;
        k_reg      <= k_next;
        m_data_reg <= m_data_next;
        m_last_reg <= m_last_next;
        m_user_reg <= m_user_next;
    end

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;
    assign m_tlast  = m_last_reg;
    assign m_tuser  = m_user_reg;

endmodule

>>> design/msort_checker.sv
// Port-level checker for merge_sorter_unit, attached by the bind below.
// Depends on msort_pkg for the stream data width.
module msort_checker
    import msort_pkg::*;
(
    input logic              clk,
    input logic              rst_n,
    input logic              s_tvalid,
    input logic              s_tready,
    input logic              s_tlast,
    input logic              m_tvalid,
    input logic              m_tready,
    input logic [DATA_W-1:0] m_tdata,
    input logic              m_tlast,
    input logic              m_tuser
);

    // A stalled result holds its payload.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast)
            && $stable(m_tuser))
        else $error("stalled result changed");

    // The request that ends a set starts the sort, so the input closes.
    a_sort_starts: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready && s_tlast |=> !s_tready)
        else $error("input stayed open after the last request");

    // Only the final result of a set may wait while new requests are taken.
    a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tlast |-> !s_tready)
        else $error("input open while a set is being emitted");

    // The dropped flag is the same on consecutive results of one set.
    a_drop_steady: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tready && !m_tlast ##1 m_tvalid |-> m_tuser == $past(m_tuser))
        else $error("dropped flag changed within a set");

endmodule

bind merge_sorter_unit msort_checker u_msort_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast),
    .m_tuser  (m_tuser)
);
